// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the fade generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/rlf_pkg.sv =====
// Types and constants of the RGB linear fade generator.
package rlf_pkg;

  localparam int COL_W  = 8;
  localparam int REM_W  = COL_W + 1;
  localparam int FADE_W = 7;
  localparam int NUM_CH = 3;
  localparam int BIT_W  = $clog2(COL_W);

  localparam logic [FADE_W-1:0] FADE_STEPS_RESET = 7'd17;

  typedef logic [1:0] ch_t;
  localparam ch_t CH_RED   = 2'd0;
  localparam ch_t CH_GREEN = 2'd1;
  localparam ch_t CH_BLUE  = 2'd2;

  typedef struct packed {
    logic [COL_W-1:0] start_red;
    logic [COL_W-1:0] start_green;
    logic [COL_W-1:0] start_blue;
    logic [COL_W-1:0] target_red;
    logic [COL_W-1:0] target_green;
    logic [COL_W-1:0] target_blue;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0] out_red;
    logic [COL_W-1:0] out_green;
    logic [COL_W-1:0] out_blue;
    logic             last_step;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic apply;
    logic out_load;
    ch_t  ch;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_full;
    logic last;
  } sts_t;

endpackage

// ===== sv/rgb_linear_fade_generator.sv =====
// Top level of the RGB linear fade generator: configuration register, controller, datapath.
// Each accepted transfer yields N result transfers, N being fade_steps clamped to 1..MAX_STEPS.
// Every step takes the three channels in turn through the shared bit-serial divider: set-up,
// one iteration per colour bit and an update each, then the output register is filled once it is free.
// The next input is taken once the last step has been handed to the output register.
// Reset (synchronous, active low) returns to idle, empties the output and sets fade_steps to 17.
`include "assert_macros.svh"

module rgb_linear_fade_generator #(
  parameter int MAX_STEPS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rlf_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rlf_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [rlf_pkg::FADE_W-1:0]    cfg_wdata
);

  localparam int STEP_W = $clog2(MAX_STEPS + 1);

  logic [rlf_pkg::FADE_W-1:0] fade_steps_r;
  logic [rlf_pkg::FADE_W-1:0] n_clamp;
  logic [STEP_W-1:0]          n_eff;
  rlf_pkg::cmd_t              cmd;
  rlf_pkg::sts_t              sts;

  // The user must write the fade length register only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_steps_r <= rlf_pkg::FADE_STEPS_RESET;
    end else if (cfg_we) begin
      fade_steps_r <= cfg_wdata;
    end
  end

  // A length of zero means a single step straight to the target; an
  // over-long setting is limited to the longest fade the counter supports.
  always_comb begin
    if (fade_steps_r == '0) begin
      n_clamp = rlf_pkg::FADE_W'(1);
    end else if (fade_steps_r > rlf_pkg::FADE_W'(MAX_STEPS)) begin
      n_clamp = rlf_pkg::FADE_W'(MAX_STEPS);
    end else begin
      n_clamp = fade_steps_r;
    end
  end
  assign n_eff = STEP_W'(n_clamp);

  // The controller steps through the divisions; the datapath holds the
  // colours, the signed remaining differences and the shared divider.
  rlf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rlf_datapath #(
    .MAX_STEPS (MAX_STEPS),
    .STEP_W    (STEP_W)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .n_eff     (n_eff),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Once a fade has started the block is busy in the next cycle.
  `AST_NEXT(a_busy_after_load, clk, rst_n, in_valid && !in_stall, in_stall)
  // A result held back by the receiver stays valid and unchanged.
  `AST_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  // The effective fade length always lies within the supported range.
  `AST_IMPLY(a_len_range, clk, rst_n, 1'b1, (n_eff != '0) && (n_eff <= STEP_W'(MAX_STEPS)))

endmodule

// ===== sv/rlf_datapath.sv =====
// Datapath of the fade generator: colour and difference registers, divider, output register.
module rlf_datapath #(
  parameter int MAX_STEPS = 64,
  parameter int STEP_W    = $clog2(MAX_STEPS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rlf_pkg::cmd_t         cmd,
  output rlf_pkg::sts_t         sts,
  input  rlf_pkg::in_t          in_data,
  input  logic [STEP_W-1:0]     n_eff,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rlf_pkg::out_t         out_data
);

  logic        [rlf_pkg::COL_W-1:0] col_r [rlf_pkg::NUM_CH];
  logic signed [rlf_pkg::REM_W-1:0] rem_r [rlf_pkg::NUM_CH];
  logic        [STEP_W-1:0]         left_r;
  logic        [rlf_pkg::COL_W-1:0] mag_r;
  logic        [STEP_W-1:0]         pr_r;
  logic                             neg_r;
  logic                             out_valid_r;
  rlf_pkg::out_t                    out_r;

  logic        [STEP_W:0]           trial;
  logic        [STEP_W:0]           diff;
  logic                             qbit;
  logic signed [rlf_pkg::REM_W-1:0] rem_sel;
  logic signed [rlf_pkg::REM_W-1:0] delta;

  // One restoring division step: bring down the next dividend bit.
  assign trial   = {pr_r, mag_r[rlf_pkg::COL_W-1]};
  assign diff    = trial - {1'b0, left_r};
  assign qbit    = (trial >= {1'b0, left_r});
  assign rem_sel = rem_r[cmd.ch];
  assign delta   = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r[rlf_pkg::CH_RED]   <= in_data.start_red;
      col_r[rlf_pkg::CH_GREEN] <= in_data.start_green;
      col_r[rlf_pkg::CH_BLUE]  <= in_data.start_blue;
      rem_r[rlf_pkg::CH_RED]   <= $signed({1'b0, in_data.target_red})
                                  - $signed({1'b0, in_data.start_red});
      rem_r[rlf_pkg::CH_GREEN] <= $signed({1'b0, in_data.target_green})
                                  - $signed({1'b0, in_data.start_green});
      rem_r[rlf_pkg::CH_BLUE]  <= $signed({1'b0, in_data.target_blue})
                                  - $signed({1'b0, in_data.start_blue});
      left_r <= n_eff;
    end
    if (cmd.div_init) begin
      neg_r <= rem_sel[rlf_pkg::REM_W-1];
      mag_r <= rem_sel[rlf_pkg::REM_W-1] ? rlf_pkg::COL_W'(-rem_sel)
                                         : rlf_pkg::COL_W'(rem_sel);
      pr_r  <= '0;
    end
    if (cmd.div_step) begin
      pr_r  <= qbit ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
      mag_r <= {mag_r[rlf_pkg::COL_W-2:0], qbit};
    end
    if (cmd.apply) begin
      col_r[cmd.ch] <= col_r[cmd.ch] + delta[rlf_pkg::COL_W-1:0];
      rem_r[cmd.ch] <= rem_r[cmd.ch] - delta;
    end
    if (cmd.out_load) begin
      out_r.out_red   <= col_r[rlf_pkg::CH_RED];
      out_r.out_green <= col_r[rlf_pkg::CH_GREEN];
      out_r.out_blue  <= col_r[rlf_pkg::CH_BLUE];
      out_r.last_step <= (left_r == STEP_W'(1));
      left_r          <= left_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_full = out_valid_r && out_stall;
  assign sts.last     = (left_r == STEP_W'(1));
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

// ===== sv/rlf_ctrl.sv =====
// Controller of the fade generator: sequences load, divisions, updates and output.
module rlf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rlf_pkg::sts_t sts,
  output rlf_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_INIT, S_DIV, S_APPLY, S_EMIT} state_t;

  state_t                     state_r;
  rlf_pkg::ch_t               ch_r;
  logic [rlf_pkg::BIT_W-1:0]  bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= rlf_pkg::CH_RED;
      bit_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_INIT;
            ch_r    <= rlf_pkg::CH_RED;
          end
        end
        S_INIT: begin
          state_r <= S_DIV;
          bit_r   <= '0;
        end
        S_DIV: begin
          bit_r <= bit_r + rlf_pkg::BIT_W'(1);
          if (bit_r == rlf_pkg::BIT_W'(rlf_pkg::COL_W - 1)) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (ch_r == rlf_pkg::CH_BLUE) begin
            state_r <= S_EMIT;
          end else begin
            ch_r    <= ch_r + rlf_pkg::ch_t'(1);
            state_r <= S_INIT;
          end
        end
        S_EMIT: begin
          if (!sts.out_full) begin
            ch_r    <= rlf_pkg::CH_RED;
            state_r <= sts.last ? S_IDLE : S_INIT;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall     = (state_r != S_IDLE);
  assign cmd.load     = (state_r == S_IDLE) && in_valid;
  assign cmd.div_init = (state_r == S_INIT);
  assign cmd.div_step = (state_r == S_DIV);
  assign cmd.apply    = (state_r == S_APPLY);
  assign cmd.out_load = (state_r == S_EMIT) && !sts.out_full;
  assign cmd.ch       = ch_r;

endmodule

// ===== dv/rgb_linear_fade_generator_tb.sv =====
// Self-checking testbench for the RGB linear fade generator.
`timescale 1ns / 1ps

module rgb_linear_fade_generator_tb;

  localparam int MAX_FADE_STEPS = 64;
  // Cycles to let pass once the last colour has arrived.
  localparam int SETTLE_CYCLES  = 40;
  // Bound on the wait for outstanding colours at a phase boundary or at the end.
  localparam int DRAIN_LIMIT    = 200000;
  // Length of the deliberate back-pressure episode on the result side.
  localparam int HOLD_CYCLES    = 400;

  // The scoreboard predicts every colour of a fade when the start/target transfer is
  // accepted, and compares each result transfer against the oldest prediction.
  class fade_scoreboard;
    rlf_pkg::out_t pending_colours[$];
    int            fault_count;

    function new();
      fault_count = 0;
    endfunction

    // Works out the whole run of colours for one accepted start/target pair.
    function void note_fade(rlf_pkg::in_t item, logic [rlf_pkg::FADE_W-1:0] steps_reg);
      int            n;
      int            colour[rlf_pkg::NUM_CH];
      int            remaining[rlf_pkg::NUM_CH];
      int            delta;
      rlf_pkg::out_t step;
      n = int'(steps_reg);
      if (n < 1) n = 1;
      if (n > MAX_FADE_STEPS) n = MAX_FADE_STEPS;
      colour[0]    = int'(item.start_red);
      colour[1]    = int'(item.start_green);
      colour[2]    = int'(item.start_blue);
      remaining[0] = int'(item.target_red) - colour[0];
      remaining[1] = int'(item.target_green) - colour[1];
      remaining[2] = int'(item.target_blue) - colour[2];
      for (int k = 0; k < n; k++) begin
        for (int c = 0; c < rlf_pkg::NUM_CH; c++) begin
          // Signed integer division truncates toward zero, as the block's divider does.
          delta        = remaining[c] / (n - k);
          colour[c]    = colour[c] + delta;
          remaining[c] = remaining[c] - delta;
        end
        step.out_red   = 8'(colour[0]);
        step.out_green = 8'(colour[1]);
        step.out_blue  = 8'(colour[2]);
        step.last_step = (k == n - 1);
        pending_colours.push_back(step);
      end
    endfunction

    function void check_colour(rlf_pkg::out_t got);
      rlf_pkg::out_t want;
      if (pending_colours.size() == 0) begin
        $error("unexpected colour %h %h %h last %b", got.out_red, got.out_green,
               got.out_blue, got.last_step);
        fault_count++;
        return;
      end
      want = pending_colours.pop_front();
      if (got.out_red !== want.out_red) begin
        $error("out_red: expected %0d, got %0d", want.out_red, got.out_red);
        fault_count++;
      end
      if (got.out_green !== want.out_green) begin
        $error("out_green: expected %0d, got %0d", want.out_green, got.out_green);
        fault_count++;
      end
      if (got.out_blue !== want.out_blue) begin
        $error("out_blue: expected %0d, got %0d", want.out_blue, got.out_blue);
        fault_count++;
      end
      if (got.last_step !== want.last_step) begin
        $error("last_step: expected %0b, got %0b", want.last_step, got.last_step);
        fault_count++;
      end
    endfunction

    function int outstanding();
      return pending_colours.size();
    endfunction

    function void check_drained();
      if (pending_colours.size() != 0) begin
        $error("%0d predicted colours never arrived", pending_colours.size());
        fault_count++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  rlf_pkg::in_t                in_data;
  logic                        out_valid;
  logic                        out_stall;
  rlf_pkg::out_t               out_data;
  logic                        cfg_we;
  logic [rlf_pkg::FADE_W-1:0]  cfg_wdata;

  fade_scoreboard              colour_check = new();

  // Testbench copy of the fade_steps register, used when predicting a fade.
  logic [rlf_pkg::FADE_W-1:0]  fade_steps_now = rlf_pkg::FADE_STEPS_RESET;
  // When set, neither side inserts idle cycles.
  bit                          quiet_mode = 1'b0;
  // Raised by the stimulus to ask the result side for one long hold-off.
  bit                          long_hold_request = 1'b0;

  typedef struct {
    logic [rlf_pkg::FADE_W-1:0] steps;
    int                         count;
    bit                         quiet;
    bit                         long_hold;
  } phase_t;

  rgb_linear_fade_generator #(
    .MAX_STEPS(MAX_FADE_STEPS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Every result transfer is checked at the rising edge on which it happens. The block's
  // outputs are read before its registers update, so this sees the values of the transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      colour_check.check_colour(out_data);
    end
  end

  // Mostly no idle cycles, sometimes a short gap, now and again a long one.
  function automatic int pick_gap();
    int roll;
    if (quiet_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // The result side. Stall is changed only at falling edges. A long hold-off, when asked for,
  // keeps stall high for HOLD_CYCLES while the sender keeps offering transfers,
  // so the output register fills and the block has to stall its input.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_request = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Offers one start/target pair and holds it until the transfer happens. The prediction is
  // made from the register value in force at that moment. A random gap may follow; when there
  // is none, valid simply stays high for the next pair.
  task automatic send_fade(rlf_pkg::in_t item);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    colour_check.note_fade(item, fade_steps_now);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Lowers valid and waits until every predicted colour has come out, then lets the block
  // settle for SETTLE_CYCLES.
  task automatic wait_for_fades_done();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (colour_check.outstanding() > 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The register is only written while the block is idle.
  task automatic write_fade_steps(logic [rlf_pkg::FADE_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    fade_steps_now = value;
  endtask

  function automatic rlf_pkg::in_t colour_pair(logic [7:0] sr, logic [7:0] sg,
                                               logic [7:0] sbl, logic [7:0] tr,
                                               logic [7:0] tg, logic [7:0] tbl);
    rlf_pkg::in_t item;
    item.start_red    = sr;
    item.start_green  = sg;
    item.start_blue   = sbl;
    item.target_red   = tr;
    item.target_green = tg;
    item.target_blue  = tbl;
    return item;
  endfunction

  // One channel's endpoints: equal, at the rails, close together, or anywhere.
  function automatic void pick_endpoints(output logic [7:0] s, output logic [7:0] t);
    int kind;
    int near;
    kind = $urandom_range(0, 9);
    s    = 8'($urandom_range(0, 255));
    case (kind)
      0: begin
        t = s;
      end
      1, 2: begin
        s = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        t = $urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(0, 255));
      end
      3, 4: begin
        near = int'(s) + $urandom_range(0, 16) - 8;
        if (near < 0) near = 0;
        if (near > 255) near = 255;
        t = 8'(near);
      end
      default: begin
        t = 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  function automatic rlf_pkg::in_t random_pair();
    rlf_pkg::in_t item;
    pick_endpoints(item.start_red, item.target_red);
    pick_endpoints(item.start_green, item.target_green);
    pick_endpoints(item.start_blue, item.target_blue);
    return item;
  endfunction

  initial begin
    rlf_pkg::in_t directed[$];
    phase_t       phases[$];

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pairs, run with the register at its reset value of 17 steps: equal endpoints
    // at both rails and in the middle, full-scale rises and falls, opposite directions on
    // different channels, alternating bit patterns and differences smaller than the step count.
    directed.push_back(colour_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    directed.push_back(colour_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    directed.push_back(colour_pair(8'h80, 8'h3C, 8'hC3, 8'h80, 8'h3C, 8'hC3));
    directed.push_back(colour_pair(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF));
    directed.push_back(colour_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
    directed.push_back(colour_pair(8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00, 8'h80));
    directed.push_back(colour_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
    directed.push_back(colour_pair(8'h0A, 8'h0B, 8'h64, 8'h0B, 8'h0A, 8'h54));
    directed.push_back(colour_pair(8'h10, 8'hEF, 8'h01, 8'h21, 8'hDE, 8'hFE));
    directed.push_back(colour_pair(8'h7F, 8'h80, 8'h01, 8'h80, 8'h7F, 8'h00));
    directed.push_back(colour_pair(8'h00, 8'h10, 8'hF0, 8'h11, 8'h00, 8'hFF));
    directed.push_back(colour_pair(8'hFE, 8'h01, 8'h33, 8'h01, 8'hFE, 8'hCC));
    foreach (directed[i]) send_fade(directed[i]);

    // Random phases, each with its own register value. A value of zero must behave as one
    // step, values above the maximum as the maximum; 127 and 0 also toggle every register
    // bit. The long runs get only a handful of pairs so the simulation stays short.
    phases.push_back('{7'd0,   25, 1'b0, 1'b0});
    phases.push_back('{7'd1,   25, 1'b1, 1'b0});
    phases.push_back('{7'd127,  4, 1'b0, 1'b0});
    phases.push_back('{7'd2,   30, 1'b0, 1'b1});
    phases.push_back('{7'd3,   30, 1'b0, 1'b0});
    phases.push_back('{7'd64,   4, 1'b1, 1'b0});
    phases.push_back('{7'd5,   30, 1'b0, 1'b0});
    phases.push_back('{7'd8,   35, 1'b0, 1'b0});
    phases.push_back('{7'd65,   3, 1'b0, 1'b0});
    phases.push_back('{7'd4,   35, 1'b1, 1'b0});
    phases.push_back('{7'd12,  25, 1'b0, 1'b0});
    phases.push_back('{7'd6,   32, 1'b0, 1'b0});

    foreach (phases[p]) begin
      // The sender pauses here until every predicted colour has been seen.
      wait_for_fades_done();
      write_fade_steps(phases[p].steps);
      quiet_mode = phases[p].quiet;
      if (phases[p].long_hold) long_hold_request = 1'b1;
      repeat (phases[p].count) send_fade(random_pair());
    end

    wait_for_fades_done();
    colour_check.check_drained();
    if (colour_check.fault_count == 0) begin
      $display("** rgb_linear_fade_generator: PASSED **");
    end else begin
      $display("** rgb_linear_fade_generator: FAILED **");
    end
    $finish;
  end

  // Hard stop, well beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("** rgb_linear_fade_generator: FAILED **");
    $finish;
  end

endmodule
